@@ hw/rtl/spiral_index_coordinate_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// Spiral mapper assertion macros
// Shared property wrappers, clocked on clk with reset rst_n held low.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_INDEX_COORDINATE_MAPPER_DEFINES_SVH
`define SPIRAL_INDEX_COORDINATE_MAPPER_DEFINES_SVH

// A property that must hold whenever the block is out of reset.
`define SICM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that, once seen, forces another one on the next clock.
`define SICM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sicm_pkg.sv @@
// ----------------------------------------------------------------------------
// Spiral mapper package
// Field widths and the record types shared by the sequencer and the leg unit.
// ----------------------------------------------------------------------------
package sicm_pkg;

    localparam int unsigned NUM_W  = 22;
    localparam int unsigned XY_W   = 11;
    localparam int unsigned POS_W  = 12;
    localparam int unsigned LEG_W  = 12;
    localparam int unsigned BASE_W = 23;

    localparam logic CMD_TO_XY  = 1'b0;
    localparam logic CMD_TO_NUM = 1'b1;

    // Walk position at the start of a leg. Positions are two's complement.
    typedef struct packed {
        logic [LEG_W-1:0]  leg_len;
        logic [BASE_W-1:0] base;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              axis_y;
        logic              neg;
    } walk_t;

    // What one leg evaluation found.
    typedef struct packed {
        logic              hit;
        logic [XY_W-1:0]   res_x;
        logic [XY_W-1:0]   res_y;
        logic [NUM_W-1:0]  res_num;
    } leg_res_t;

endpackage

@@ hw/rtl/sicm_leg_unit.sv @@
// ----------------------------------------------------------------------------
// Spiral mapper leg unit
// Evaluates one leg of the spiral walk: decides whether the target lies on
// it and otherwise advances to the start of the next leg.
// ----------------------------------------------------------------------------
module sicm_leg_unit
(
    input  logic                          cmd,
    input  logic [sicm_pkg::NUM_W-1:0]    number,
    input  logic [sicm_pkg::XY_W-1:0]     qx,
    input  logic [sicm_pkg::XY_W-1:0]     qy,
    input  sicm_pkg::walk_t               cur,
    output sicm_pkg::walk_t               nxt,
    output sicm_pkg::leg_res_t            res
);

    logic [sicm_pkg::POS_W-1:0]  qx_ext;
    logic [sicm_pkg::POS_W-1:0]  qy_ext;
    logic [sicm_pkg::POS_W-1:0]  q_along;
    logic [sicm_pkg::POS_W-1:0]  q_other;
    logic [sicm_pkg::POS_W-1:0]  p_along;
    logic [sicm_pkg::POS_W-1:0]  p_other;
    logic [sicm_pkg::BASE_W-1:0] d_num;
    logic                        num_fits;
    logic [sicm_pkg::POS_W:0]    diff;
    logic [sicm_pkg::POS_W:0]    d_q;
    logic                        q_hit;
    logic [sicm_pkg::LEG_W-1:0]  amt;
    logic [sicm_pkg::POS_W:0]    step;
    logic [sicm_pkg::POS_W:0]    along_sum;
    logic [sicm_pkg::POS_W-1:0]  along_new;
    logic [sicm_pkg::BASE_W-1:0] base_add;
    logic [sicm_pkg::BASE_W-1:0] base_new;

    always_comb
    begin
        qx_ext  = {qx[sicm_pkg::XY_W-1], qx};
        qy_ext  = {qy[sicm_pkg::XY_W-1], qy};
        q_along = cur.axis_y ? qy_ext : qx_ext;
        q_other = cur.axis_y ? qx_ext : qy_ext;
        p_along = cur.axis_y ? cur.pos_y : cur.pos_x;
        p_other = cur.axis_y ? cur.pos_x : cur.pos_y;

        // Number search: the leg holds base+1 .. base+leg_len.
        d_num    = {1'b0, number} - cur.base;
        num_fits = (d_num <= {11'd0, cur.leg_len});

        // Coordinate search: distance along the leg in walking direction.
        diff  = {q_along[sicm_pkg::POS_W-1], q_along} - {p_along[sicm_pkg::POS_W-1], p_along};
        d_q   = cur.neg ? (13'd0 - diff) : diff;
        q_hit = (q_other == p_other) && !d_q[sicm_pkg::POS_W] && (d_q != 13'd0)
                && (d_q[sicm_pkg::POS_W-1:0] <= cur.leg_len);

        // One position adder and one index adder serve both the hit and the step.
        amt       = (cmd == sicm_pkg::CMD_TO_XY && num_fits) ? d_num[sicm_pkg::LEG_W-1:0]
                                                             : cur.leg_len;
        step      = cur.neg ? (13'd0 - {1'b0, amt}) : {1'b0, amt};
        along_sum = {p_along[sicm_pkg::POS_W-1], p_along} + step;
        along_new = along_sum[sicm_pkg::POS_W-1:0];

        base_add = (cmd == sicm_pkg::CMD_TO_NUM && q_hit)
                   ? {11'd0, d_q[sicm_pkg::POS_W-1:0]} : {11'd0, cur.leg_len};
        base_new = cur.base + base_add;

        nxt.leg_len = cur.axis_y ? (cur.leg_len + 12'd1) : cur.leg_len;
        nxt.base    = base_new;
        nxt.pos_x   = cur.axis_y ? cur.pos_x : along_new;
        nxt.pos_y   = cur.axis_y ? along_new : cur.pos_y;
        nxt.axis_y  = !cur.axis_y;
        nxt.neg     = cur.axis_y ? !cur.neg : cur.neg;

        res.hit     = (cmd == sicm_pkg::CMD_TO_NUM) ? q_hit : num_fits;
        res.res_x   = (cmd == sicm_pkg::CMD_TO_NUM) ? qx
                    : (cur.axis_y ? cur.pos_x[sicm_pkg::XY_W-1:0]
                                  : along_new[sicm_pkg::XY_W-1:0]);
        res.res_y   = (cmd == sicm_pkg::CMD_TO_NUM) ? qy
                    : (cur.axis_y ? along_new[sicm_pkg::XY_W-1:0]
                                  : cur.pos_y[sicm_pkg::XY_W-1:0]);
        res.res_num = (cmd == sicm_pkg::CMD_TO_NUM) ? base_new[sicm_pkg::NUM_W-1:0]
                                                    : 22'd0;
    end

endmodule

@@ hw/rtl/spiral_index_coordinate_mapper.sv @@
// ----------------------------------------------------------------------------
// Square spiral index / coordinate mapper
// Walks the square spiral one leg per cycle to convert a spiral number to its
// grid position, or a grid position to the number found there.
// ----------------------------------------------------------------------------
// Usage:
// One request beat enters on the s_ group. s_tuser picks the command: 0 maps
// spiral_number to (x,y), 1 maps (query_x,query_y) to a number. One result
// beat leaves on the m_ group; m_tuser carries range_error.
// The block takes a request only while it is idle, then walks the spiral from
// the origin, one whole leg (1,1,2,2,3,3,... steps) per clock in the shared
// leg unit, until the target lies on the current leg. A request whose target
// lies on leg L walks legs 1 to L; L is about 2*sqrt(n) for number n, or
// about 4*max(|x|,|y|) for a coordinate. The last cell of the default spiral,
// (1023,-1023), lies on leg 4093, which sets the worst case; a larger radius
// admits the whole coordinate field and raises it to 4097 legs. Out-of-range
// requests and the origin query skip the walk and load their result once the
// output register is free. The next request is taken the cycle after a result
// is loaded, while that result may still sit in the output register.
// Reset clears the sequencer and drops m_tvalid. If the receiver stalls, the
// result beat holds; a finished walk then waits in place until the output
// register frees, and s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module spiral_index_coordinate_mapper
#(
    parameter int MAX_RADIUS = 1023
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // spiral_number[21:0], query_x[32:22], query_y[43:33], zero pad
    input  logic        s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // result_x[10:0], result_y[21:11], result_number[43:22], pad
    output logic        m_tuser   // range_error
);

    // The spiral holds (2R+1)^2 numbers; a limit beyond the field never trips.
    localparam longint unsigned SPAN      = 2 * MAX_RADIUS + 1;
    localparam longint unsigned LIMIT     = SPAN * SPAN;
    localparam logic [21:0]     NUM_LIMIT = (LIMIT > 64'h3F_FFFF) ? 22'h3F_FFFF : 22'(LIMIT);
    // Coordinates carry at most a magnitude of 1024, so a clamp to 12 bits is exact.
    localparam logic [11:0]     RAD_LIMIT = (MAX_RADIUS > 2047) ? 12'd2047 : 12'(MAX_RADIUS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                          state_reg,     state_next;
    logic                          cmd_reg,       cmd_next;
    logic [sicm_pkg::NUM_W-1:0]    number_reg,    number_next;
    logic [sicm_pkg::XY_W-1:0]     qx_reg,        qx_next;
    logic [sicm_pkg::XY_W-1:0]     qy_reg,        qy_next;
    logic                          quick_reg,     quick_next;
    logic                          err_reg,       err_next;
    sicm_pkg::walk_t               walk_reg,      walk_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sicm_pkg::XY_W-1:0]     out_x_reg,     out_x_next;
    logic [sicm_pkg::XY_W-1:0]     out_y_reg,     out_y_next;
    logic [sicm_pkg::NUM_W-1:0]    out_num_reg,   out_num_next;
    logic                          out_err_reg,   out_err_next;

    sicm_pkg::walk_t               leg_nxt;
    sicm_pkg::leg_res_t            leg_res;

    logic [sicm_pkg::NUM_W-1:0]    in_number;
    logic [sicm_pkg::XY_W-1:0]     in_qx;
    logic [sicm_pkg::XY_W-1:0]     in_qy;
    logic [11:0]                   abs_x;
    logic [11:0]                   abs_y;
    logic                          in_err;
    logic                          in_origin;
    logic                          slot_free;

    sicm_leg_unit u_leg
    (
        .cmd    (cmd_reg),
        .number (number_reg),
        .qx     (qx_reg),
        .qy     (qy_reg),
        .cur    (walk_reg),
        .nxt    (leg_nxt),
        .res    (leg_res)
    );

    // Range screening of the incoming request beat.
    always_comb
    begin
        in_number = s_tdata[21:0];
        in_qx     = s_tdata[32:22];
        in_qy     = s_tdata[43:33];
        abs_x     = in_qx[10] ? (12'd0 - {in_qx[10], in_qx}) : {1'b0, in_qx};
        abs_y     = in_qy[10] ? (12'd0 - {in_qy[10], in_qy}) : {1'b0, in_qy};
        if (s_tuser == sicm_pkg::CMD_TO_NUM)
        begin
            in_err = (abs_x > RAD_LIMIT) || (abs_y > RAD_LIMIT);
        end
        else
        begin
            in_err = (in_number == 22'd0) || (in_number > NUM_LIMIT);
        end
        // The origin is number 1 and is not on any leg of the walk.
        in_origin = (s_tuser == sicm_pkg::CMD_TO_NUM) && (in_qx == 11'd0) && (in_qy == 11'd0);
    end

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        number_next    = number_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        quick_next     = quick_reg;
        err_next       = err_reg;
        walk_next      = walk_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_num_next   = out_num_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next           = s_tuser;
                    number_next        = in_number;
                    qx_next            = in_qx;
                    qy_next            = in_qy;
                    err_next           = in_err;
                    quick_next         = in_err || in_origin;
                    walk_next.leg_len  = 12'd1;
                    walk_next.base     = 23'd1;
                    walk_next.pos_x    = 12'd0;
                    walk_next.pos_y    = 12'd0;
                    walk_next.axis_y   = 1'b0;
                    walk_next.neg      = 1'b0;
                    state_next         = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (quick_reg)
                begin
                    // Errors and the origin query need no walk.
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_x_next     = (cmd_reg == sicm_pkg::CMD_TO_NUM) ? qx_reg : 11'd0;
                        out_y_next     = (cmd_reg == sicm_pkg::CMD_TO_NUM) ? qy_reg : 11'd0;
                        out_num_next   = {21'd0, !err_reg};
                        out_err_next   = err_reg;
                        state_next     = ST_IDLE;
                    end
                end
                else if (leg_res.hit)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_x_next     = leg_res.res_x;
                        out_y_next     = leg_res.res_y;
                        out_num_next   = leg_res.res_num;
                        out_err_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    walk_next = leg_nxt;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        number_reg  <= number_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        quick_reg   <= quick_next;
        err_reg     <= err_next;
        walk_reg    <= walk_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_num_reg <= out_num_next;
        out_err_reg <= out_err_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_num_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_err_reg;

endmodule

@@ hw/rtl/sicm_checker.sv @@
// ----------------------------------------------------------------------------
// Spiral mapper port checker
// Watches the stream ports of the mapper and flags broken behavior.
// ----------------------------------------------------------------------------
`include "spiral_index_coordinate_mapper_defines.svh"

module sicm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    logic [48:0] m_beat;
    logic [21:0] m_number;

    assign m_beat   = {m_tuser, m_tdata};
    assign m_number = m_tdata[43:22];

    // A stalled result beat stays offered and unchanged.
    `SICM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
    `SICM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_beat), "result beat changed")
    // A request beat makes the block busy for at least the next cycle.
    `SICM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    // A range error never reports a number.
    `SICM_ASSERT(a_err_no_number, m_tvalid && m_tuser |-> m_number == 22'd0, "error with a number")

endmodule

bind spiral_index_coordinate_mapper sicm_checker u_sicm_checker (.*);
